/* hw/rtl/histogram_sum_of_squares_macros.svh */
// ----------------------------------------------------------------------------
// histogram_sum_of_squares_macros.svh
// Assertion macros used by the checker file of the histogram block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_SUM_OF_SQUARES_MACROS_SVH
`define HISTOGRAM_SUM_OF_SQUARES_MACROS_SVH

// same-cycle implication
`define HSOS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSOS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/hsos_pkg.sv */
// ----------------------------------------------------------------------------
// hsos_pkg
// Widths, defaults and control bundles of the histogram / sum-of-squares block.
// ----------------------------------------------------------------------------
package hsos_pkg;

   localparam int FB_W            = 8;   // feedback field
   localparam int MAX_W           = 6;   // max_value register
   localparam int IDX_W           = 6;   // bin_index field
   localparam int CNT_OUT_W       = 16;  // bin_count field
   localparam int SUM_W           = 32;  // running_sum field
   localparam int NUM_BINS_DEF    = 64;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic [MAX_W-1:0] MAX_VALUE_RST = 6'd63;

   // bin memory controls
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } ram_ctl_type;

   // square / accumulate controls
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clr;
   } acc_ctl_type;

endpackage

/* hw/rtl/hsos_ifs.sv */
// ----------------------------------------------------------------------------
// hsos_ifs
// Valid/ready channels of the histogram block: item in, result out, register.
// ----------------------------------------------------------------------------
interface hsos_req_if;
   logic                         valid;
   logic                         ready;
   logic [hsos_pkg::FB_W-1:0]    feedback;
   logic                         list_end;

   modport source (output valid, output feedback, output list_end, input ready);
   modport sink   (input valid, input feedback, input list_end, output ready);
endinterface

interface hsos_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsos_pkg::IDX_W-1:0]     bin_index;
   logic [hsos_pkg::CNT_OUT_W-1:0] bin_count;
   logic [hsos_pkg::SUM_W-1:0]     running_sum;
   logic                           range_error;
   logic                           final_result;

   modport source (output valid, output bin_index, output bin_count,
                   output running_sum, output range_error, output final_result,
                   input ready);
   modport sink   (input valid, input bin_index, input bin_count,
                   input running_sum, input range_error, input final_result,
                   output ready);
endinterface

interface hsos_csr_if;
   logic                        valid;
   logic                        ready;
   logic [hsos_pkg::MAX_W-1:0]  max_value;

   modport source (output valid, output max_value, input ready);
   modport sink   (input valid, input max_value, output ready);
endinterface

/* hw/rtl/hsos_bin_ram.sv */
// ----------------------------------------------------------------------------
// hsos_bin_ram
// Bin count memory, one write and one registered read per cycle. Per-entry
// valid bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module hsos_bin_ram #(
   parameter int NUM_BINS    = hsos_pkg::NUM_BINS_DEF,
   parameter int COUNT_WIDTH = hsos_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hsos_pkg::ram_ctl_type         ctl,
   input  logic [$clog2(NUM_BINS)-1:0]   rd_addr,
   input  logic [$clog2(NUM_BINS)-1:0]   wr_addr,
   input  logic [COUNT_WIDTH-1:0]        wr_data,
   output logic [COUNT_WIDTH-1:0]        rd_data
);

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]    valid_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* hw/rtl/hsos_sq_acc.sv */
// ----------------------------------------------------------------------------
// hsos_sq_acc
// Squares one bin count into a register, then adds it to the running sum.
// ----------------------------------------------------------------------------
module hsos_sq_acc #(
   parameter int COUNT_WIDTH = hsos_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hsos_pkg::acc_ctl_type         ctl,
   input  logic [COUNT_WIDTH-1:0]        count_in,
   output logic [COUNT_WIDTH-1:0]        count_q,
   output logic [hsos_pkg::SUM_W-1:0]    sum_next
);

   localparam int PW = 2 * COUNT_WIDTH;
   localparam int SW = hsos_pkg::SUM_W;

   logic [PW-1:0]          prod;
   logic [SW-1:0]          sq_in;
   logic [SW-1:0]          sq_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [SW-1:0]          sum_ff;

   assign prod     = PW'(count_in) * PW'(count_in);
   assign sq_in    = SW'(prod);       // square modulo 2^32
   assign sum_next = sum_ff + sq_ff;
   assign count_q  = count_ff;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         sq_ff    <= sq_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         sum_ff <= '0;
      end else if (ctl.acc_en) begin
         sum_ff <= sum_next;
      end
   end

endmodule

/* hw/rtl/histogram_sum_of_squares.sv */
// ----------------------------------------------------------------------------
// histogram_sum_of_squares
// Counts feedback values into bins and reports counts with a running sum of
// squared counts at the end of each list.
// ----------------------------------------------------------------------------
// Items arrive on req_bus (feedback, list_end); a transfer needs valid and
// ready high at a clock edge. Each in-range value bumps its bin in a
// registered-read memory; a value above the top bin only sets the sticky
// range error. Counting takes one item per cycle while req_bus.ready is
// high: read at transfer, modify and write back in the next cycle, with the
// last write forwarded when the next item hits the same bin.
// The item with list_end is counted, then req_bus.ready drops and the block
// reports bins 0 through min(max_value, NUM_BINS-1) on rsp_bus, one result
// per bin. Each bin passes through a memory read (ST_READ), a square
// (ST_MUL) and an accumulate (ST_OUT), where a stalled receiver waits;
// the last result carries final_result. After it all bins, the error
// flag and the sum are cleared and req_bus.ready rises again.
// rsp_bus has an output register: a stalled receiver holds the burst, and
// the final result may wait there while the next list is already counted.
// csr_bus writes max_value, always ready. Reset (synchronous) empties the
// bins, sets max_value to 63 and is ready the next cycle.
// ----------------------------------------------------------------------------
module histogram_sum_of_squares #(
   parameter int NUM_BINS    = hsos_pkg::NUM_BINS_DEF,
   parameter int COUNT_WIDTH = hsos_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hsos_req_if.sink    req_bus,
   hsos_rsp_if.source  rsp_bus,
   hsos_csr_if.sink    csr_bus
);

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int FB_W  = hsos_pkg::FB_W;
   localparam logic [FB_W-1:0] LAST_BIN = FB_W'(NUM_BINS - 1);

   localparam logic [2:0] ST_COUNT = 3'd0;
   localparam logic [2:0] ST_WAIT  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [hsos_pkg::MAX_W-1:0]     max_value_ff;
   logic [FB_W-1:0]                max8, top8;
   logic                           req_take, req_hit;

   logic                           s1_valid_ff, s1_hit_ff;
   logic [BIN_W-1:0]               s1_addr_ff;
   logic                           fwd_valid_ff;
   logic [BIN_W-1:0]               fwd_addr_ff;
   logic [COUNT_WIDTH-1:0]         fwd_data_ff;
   logic [COUNT_WIDTH-1:0]         old_count, new_count;

   logic                           error_ff;
   logic [BIN_W-1:0]               top_ff, bin_ff, bin_in;
   logic                           last_bin, out_load;

   hsos_pkg::ram_ctl_type          ram_ctl;
   hsos_pkg::acc_ctl_type          acc_ctl;
   logic [BIN_W-1:0]               ram_rd_addr;
   logic [COUNT_WIDTH-1:0]         ram_rd_data;
   logic [COUNT_WIDTH-1:0]         acc_count;
   logic [hsos_pkg::SUM_W-1:0]     acc_sum_next;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hsos_pkg::IDX_W-1:0]     rsp_index_ff;
   logic [hsos_pkg::CNT_OUT_W-1:0] rsp_count_ff;
   logic [hsos_pkg::SUM_W-1:0]     rsp_sum_ff;
   logic                           rsp_error_ff, rsp_final_ff;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff <= hsos_pkg::MAX_VALUE_RST;
      end else if (csr_bus.valid) begin
         max_value_ff <= csr_bus.max_value;
      end
   end

   // top bin is the smaller of max_value and the last bin
   assign max8    = FB_W'(max_value_ff);
   assign top8    = (max8 > LAST_BIN) ? LAST_BIN : max8;
   assign req_bus.ready = (state_ff == ST_COUNT);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_hit  = (req_bus.feedback <= top8);

   // count stage: read at transfer, update in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= req_take;
         fwd_valid_ff <= ram_ctl.wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_hit_ff  <= req_hit;
         s1_addr_ff <= req_bus.feedback[BIN_W-1:0];
      end
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_count;
   end

   // the write at the read's own edge is not in the read data
   assign old_count = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff
                                                                    : ram_rd_data;
   assign new_count = (&old_count) ? old_count : old_count + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff <= 1'b0;
      end else if (out_load && last_bin) begin
         error_ff <= 1'b0;
      end else if (s1_valid_ff && !s1_hit_ff) begin
         error_ff <= 1'b1;
      end
   end

   // burst sequencer
   assign last_bin = (bin_ff == top_ff);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      case (state_ff)
         ST_COUNT: begin
            if (req_take && req_bus.list_end) begin
               state_in = ST_WAIT;
               bin_in   = '0;
            end
         end
         ST_WAIT: state_in = ST_READ;
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               if (last_bin) begin
                  state_in = ST_COUNT;
               end else begin
                  state_in = ST_READ;
                  bin_in   = bin_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_COUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (req_take && req_bus.list_end) begin
         top_ff <= top8[BIN_W-1:0];
      end
   end

   // memory and arithmetic controls
   always_comb begin
      ram_ctl.rd_en   = (req_take && req_hit) || (state_ff == ST_READ);
      ram_ctl.wr_en   = s1_valid_ff && s1_hit_ff;
      ram_ctl.clr_all = out_load && last_bin;
      acc_ctl.mul_en  = (state_ff == ST_MUL);
      acc_ctl.acc_en  = out_load;
      acc_ctl.clr     = (out_load && last_bin) || (state_ff == ST_WAIT);
   end

   assign ram_rd_addr = (state_ff == ST_READ) ? bin_ff : req_bus.feedback[BIN_W-1:0];

   hsos_bin_ram #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_addr (ram_rd_addr),
      .wr_addr (s1_addr_ff),
      .wr_data (new_count),
      .rd_data (ram_rd_data)
   );

   hsos_sq_acc #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .ctl      (acc_ctl),
      .count_in (ram_rd_data),
      .count_q  (acc_count),
      .sum_next (acc_sum_next)
   );

   // result register
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff <= hsos_pkg::IDX_W'(bin_ff);
         rsp_count_ff <= hsos_pkg::CNT_OUT_W'(acc_count);
         rsp_sum_ff   <= acc_sum_next;
         rsp_error_ff <= error_ff;
         rsp_final_ff <= last_bin;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.bin_index    = rsp_index_ff;
   assign rsp_bus.bin_count    = rsp_count_ff;
   assign rsp_bus.running_sum  = rsp_sum_ff;
   assign rsp_bus.range_error  = rsp_error_ff;
   assign rsp_bus.final_result = rsp_final_ff;

endmodule

/* hw/rtl/hsos_checker.sv */
// ----------------------------------------------------------------------------
// hsos_checker
// Port-level checks of the histogram block, bound to its top level.
// ----------------------------------------------------------------------------
`include "histogram_sum_of_squares_macros.svh"

module hsos_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_list_end,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [hsos_pkg::IDX_W-1:0]     bin_index,
   input logic [hsos_pkg::CNT_OUT_W-1:0] bin_count,
   input logic [hsos_pkg::SUM_W-1:0]     running_sum,
   input logic                           range_error,
   input logic                           final_result
);

   localparam logic [hsos_pkg::IDX_W-1:0] TOP_INDEX = '1;

   // stalled result holds still
   `HSOS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(bin_index) && $stable(bin_count) && $stable(running_sum) && $stable(range_error) && $stable(final_result), "stalled result changed")

   // a list end closes the input
   `HSOS_ASSERT_NXT(a_end_closes, clock, reset, req_valid && req_ready && req_list_end, !req_ready, "input open right after list end")

   // a pending non-final result means the burst is still running
   `HSOS_ASSERT_IMP(a_burst_blocks, clock, reset, rsp_valid && !final_result, !req_ready, "input open during burst")

   // the highest bin index can only be the last of a burst
   `HSOS_ASSERT_IMP(a_top_final, clock, reset, rsp_valid && (bin_index == TOP_INDEX), final_result, "top bin not marked final")

endmodule

bind histogram_sum_of_squares hsos_checker u_hsos_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_list_end (req_bus.list_end),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .bin_index    (rsp_bus.bin_index),
   .bin_count    (rsp_bus.bin_count),
   .running_sum  (rsp_bus.running_sum),
   .range_error  (rsp_bus.range_error),
   .final_result (rsp_bus.final_result)
);
